// ===== rtl/core/tli_pkg.sv =====
// shared types and constants for the table linear interpolator
// no dependencies; imported by the controller, datapath and top level
package tli_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index is paddr[2]
  localparam logic REG_POINTS_IN_USE = 1'b0;
  localparam logic [8:0] POINTS_RESET = 9'd2;

  // shift-add multiply and restoring divide both take 32 steps
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    start;
    rd_sel_t rd_sel;
    logic    take_y;
    logic    init_search;
    logic    pick_mid;
    logic    cap_a;
    logic    narrow;
    logic    setup_mul;
    logic    mul_step;
    logic    div_step;
    logic    finish;
    logic    fail;
    logic    push;
  } tli_cmd_t;

  typedef struct packed {
    logic q_le_x;
    logic q_ge_x;
    logic lo_gt_hi;
    logic bracket_ok;
    logic last;
    logic out_free;
  } tli_stat_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_CHK0 = 10'b00_0000_0010,
    ST_CHKN = 10'b00_0000_0100,
    ST_SRCH = 10'b00_0000_1000,
    ST_MIDA = 10'b00_0001_0000,
    ST_MIDB = 10'b00_0010_0000,
    ST_MUL  = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_FIN  = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } tli_state_t;

endpackage

// ===== rtl/core/tli_in_if.sv =====
// input channel of the interpolator: load or query word
// no dependencies
interface tli_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;

  modport source (output valid, op, point_index, point_x, point_y, query_x, input ready);
  modport sink   (input valid, op, point_index, point_x, point_y, query_x, output ready);
endinterface

// ===== rtl/core/tli_out_if.sv =====
// result channel of the interpolator
// no dependencies
interface tli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_y;
  logic               search_failed;

  modport source (output valid, result_y, search_failed, input ready);
  modport sink   (input valid, result_y, search_failed, output ready);
endinterface

// ===== rtl/core/tli_ctrl.sv =====
// sequencer of the interpolator: search, multiply and divide steps
// depends on tli_pkg
module tli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  tli_pkg::tli_stat_t  stat,
  output tli_pkg::tli_cmd_t   cmd
);
  import tli_pkg::*;

  tli_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = ST_CHK0;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_CHK0: begin
        if (stat.q_le_x) begin
          cmd.take_y = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_nxt  = ST_CHKN;
        end
      end
      ST_CHKN: begin
        if (stat.q_ge_x) begin
          cmd.take_y = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          cmd.init_search = 1'b1;
          state_nxt       = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (stat.lo_gt_hi) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.pick_mid = 1'b1;
          cmd.rd_sel   = RD_MID;
          state_nxt    = ST_MIDA;
        end
      end
      ST_MIDA: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = RD_NEXT;
        state_nxt  = ST_MIDB;
      end
      ST_MIDB: begin
        if (stat.bracket_ok) begin
          cmd.setup_mul = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_MUL;
        end else if (stat.last) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = ST_SRCH;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && cnt_r == STEP_LAST) |=> (state_r == ST_DIV))
    else $error("multiply did not hand over to divide");

  a_mul_needs_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIDB && state_nxt == ST_MUL) |-> stat.bracket_ok)
    else $error("interpolation started without a bracketing segment");
`endif

endmodule

// ===== rtl/core/tli_dp.sv =====
// datapath of the interpolator: breakpoint memory, search bounds,
// shift-add multiplier, restoring divider and result register; depends on tli_pkg
module tli_dp #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [8:0]         points_in_use,
  input  logic [7:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  input  tli_pkg::tli_cmd_t  cmd,
  output tli_pkg::tli_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] result_y,
  output logic               search_failed
);
  import tli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned LW = AW + 1;

  logic [63:0]        tbl_r [MAX_POINTS];
  logic [63:0]        rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] q_r;
  logic [CW-1:0]      n_r;
  logic signed [LW-1:0] lo_r, hi_r;
  logic [AW-1:0]      mid_r;
  logic               last_r;
  logic [63:0]        a_r;
  logic [31:0]        mag_r;
  logic [31:0]        dx_r;
  logic               neg_r;
  logic [63:0]        prod_r;
  logic signed [31:0] res_r;
  logic               fail_r;
  logic               out_valid_r;

  logic signed [31:0] rd_x, rd_y, a_x, a_y;
  logic [CW-1:0]      n_clamp;
  logic signed [LW:0] mid_sum;
  logic [AW-1:0]      mid_comb;
  logic signed [32:0] dy;
  logic [32:0]        dy_mag;
  logic [32:0]        mul_sum;
  logic [32:0]        trial;
  logic [32:0]        trial_diff;
  logic               trial_ge;
  logic signed [32:0] delta;
  logic signed [33:0] y_sum;
  logic signed [31:0] y_sat;

  assign rd_x = signed'(rd_data_r[63:32]);
  assign rd_y = signed'(rd_data_r[31:0]);
  assign a_x  = signed'(a_r[63:32]);
  assign a_y  = signed'(a_r[31:0]);

  always_comb begin
    if (32'(points_in_use) < 32'd2) begin
      n_clamp = CW'(2);
    end else if (32'(points_in_use) > 32'(MAX_POINTS)) begin
      n_clamp = CW'(MAX_POINTS);
    end else begin
      n_clamp = CW'(points_in_use);
    end
  end

  assign mid_sum  = {lo_r[LW-1], lo_r} + {hi_r[LW-1], hi_r};
  assign mid_comb = mid_sum[AW:1];

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = AW'(n_r - CW'(1));
      RD_MID:  rd_addr = mid_comb;
      RD_NEXT: rd_addr = mid_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  // breakpoint memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(point_index) < 32'(MAX_POINTS))) begin
      tbl_r[AW'(point_index)] <= {point_x, point_y};
    end
    rd_data_r <= tbl_r[rd_addr];
  end

  // segment set-up from the two bracketing points
  assign dy     = {rd_y[31], rd_y} - {a_y[31], a_y};
  assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);

  // one multiplier bit and one quotient bit a step
  assign mul_sum    = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mag_r} : 33'd0);
  assign trial      = {prod_r[63:32], prod_r[31]};
  assign trial_diff = trial - {1'b0, dx_r};
  assign trial_ge   = (trial >= {1'b0, dx_r});

  assign delta = neg_r ? -signed'({1'b0, prod_r[31:0]}) : signed'({1'b0, prod_r[31:0]});
  assign y_sum = 34'(a_y) + 34'(delta);

  always_comb begin
    if (y_sum > 34'sd2147483647) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (y_sum < -34'sd2147483648) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat = y_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r <= query_x;
      n_r <= n_clamp;
    end
    if (cmd.init_search) begin
      lo_r <= '0;
      hi_r <= signed'(LW'(n_r) - LW'(2));
    end
    if (cmd.pick_mid) begin
      mid_r  <= mid_comb;
      last_r <= (lo_r == hi_r);
    end
    if (cmd.cap_a) begin
      a_r <= rd_data_r;
    end
    if (cmd.narrow) begin
      if (q_r < a_x) begin
        hi_r <= signed'({1'b0, mid_r} - LW'(1));
      end else begin
        lo_r <= signed'({1'b0, mid_r} + LW'(1));
      end
    end
    if (cmd.setup_mul) begin
      mag_r  <= dy_mag[31:0];
      neg_r  <= dy[32];
      dx_r   <= 32'(rd_x - a_x);
      prod_r <= {32'd0, 32'(q_r - a_x)};
    end
    if (cmd.mul_step) begin
      prod_r <= {mul_sum, prod_r[31:1]};
    end
    if (cmd.div_step) begin
      prod_r <= {(trial_ge ? trial_diff[31:0] : trial[31:0]), prod_r[30:0], trial_ge};
    end
    if (cmd.take_y) begin
      res_r  <= rd_y;
      fail_r <= 1'b0;
    end
    if (cmd.fail) begin
      res_r  <= '0;
      fail_r <= 1'b1;
    end
    if (cmd.finish) begin
      res_r  <= y_sat;
      fail_r <= 1'b0;
    end
  end

  // output register
  logic               ov_nxt;
  logic signed [31:0] oy_r;
  logic               of_r;

  always_comb begin
    ov_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.push) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      oy_r <= res_r;
      of_r <= fail_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign result_y      = oy_r;
  assign search_failed = of_r;

  assign stat.q_le_x     = (q_r <= rd_x);
  assign stat.q_ge_x     = (q_r >= rd_x);
  assign stat.lo_gt_hi   = (lo_r > hi_r);
  assign stat.bracket_ok = (a_x <= q_r) && (q_r < rd_x);
  assign stat.last       = last_r;
  assign stat.out_free   = !out_valid_r || out_ready;

`ifndef SYNTH
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over an unread word");

  a_next_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_sel == RD_NEXT) |-> ((32'(mid_r) + 32'd1) < 32'(n_r)))
    else $error("upper breakpoint beyond points in use");

  a_dx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (dx_r != '0))
    else $error("divide by zero segment width");
`endif

endmodule

// ===== rtl/core/table_linear_interpolator_unit.sv =====
// top level of the table linear interpolator: channels, apb register, sequencer and datapath
// depends on tli_pkg, tli_in_if, tli_out_if, tli_ctrl and tli_dp
//
// usage
//   in_ch carries one word per item: op selects load (write point_x/point_y into
//   slot point_index) or query (interpolate at query_x). out_ch returns one word
//   per query: result_y (signed q16.16, saturated) and search_failed.
//   loads are taken in idle and give no result; slots at or above MAX_POINTS are ignored.
//   points_in_use (apb register at byte 0, reset 2) is clamped to 2..MAX_POINTS.
// query sequence and throughput
//   a query at or beyond the table ends goes from CHK0 or CHKN straight to DONE;
//   an interior query runs k binary search steps (at most log2(MAX_POINTS)),
//   each through SRCH, MIDA and MIDB as the single memory read port serves one
//   point at a time, then the bit-serial 32-step multiply and 32-step divide;
//   items are taken one at a time; the next word is accepted once the
//   result has moved into the output register
// reset and stalls
//   rst_n (synchronous) empties the output register and returns the sequencer to idle;
//   table contents are undefined until loaded. a stalled receiver holds the result
//   word, and a finished query waits until the output register is free
module table_linear_interpolator_unit #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  tli_in_if.sink      in_ch,
  tli_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tli_pkg::*;

  logic       points_sel;
  logic [8:0] points_in_use_r;
  tli_cmd_t   cmd;
  tli_stat_t  stat;
  logic       in_ready;
  logic       cfg_wr;

  // configuration register, to be written only while idle; the block does not enforce this
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign points_sel = (cfg_paddr[2] == REG_POINTS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r <= POINTS_RESET;
    end else if (cfg_wr && points_sel) begin
      points_in_use_r <= cfg_pwdata[8:0];
    end
  end

  assign cfg_prdata = points_sel ? {23'd0, points_in_use_r} : 32'd0;

  assign in_ch.ready = in_ready;

  // sequencer
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memory and arithmetic
  tli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .points_in_use (points_in_use_r),
    .point_index   (in_ch.point_index),
    .point_x       (in_ch.point_x),
    .point_y       (in_ch.point_y),
    .query_x       (in_ch.query_x),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .result_y      (out_ch.result_y),
    .search_failed (out_ch.search_failed)
  );

endmodule

// ===== test/table_linear_interpolator_unit_tb.sv =====
// self-checking testbench for table_linear_interpolator_unit: directed table, then random load/query phases
// depends on tli_pkg, tli_in_if, tli_out_if and the block itself
// every result word is predicted in-bench or given by the directed table, and compared in order with the result channel
module table_linear_interpolator_unit_tb;
  import tli_pkg::*;

  localparam int NSLOTS = 256;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 120;
  localparam int HOLD_OFF = 400;
  localparam logic REG_SPARE = 1'b1; // second register slot, nothing behind it

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic [7:0]  idx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] qx;
    bit          fixed;
    logic [31:0] ey;
    logic        ef;
  } dir_row_t;

  typedef struct {
    logic signed [31:0] y;
    logic               f;
  } lerp_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();

  table_linear_interpolator_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow copy of the breakpoint table and the point count
  longint    bp_x [NSLOTS];
  longint    bp_y [NSLOTS];
  bit        bp_set [NSLOTS];
  logic [8:0] pts_shadow = POINTS_RESET;

  lerp_res_t pending_y [$];
  dir_row_t  dir_rows [$];
  int        bad_cnt = 0;
  int        words_sent = 0;
  int        cyc = 0;
  bit        calm = 1'b0;     // no idling on either side while set
  int        hold_ask = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.point_index = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.query_x = '0;
    out_ch.ready = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void note_bad(string msg);
    if (bad_cnt < 10) $display("mismatch: %s", msg);
    bad_cnt++;
  endfunction

  function automatic int eff_points();
    int n;
    n = pts_shadow;
    if (n < 2) n = 2;
    if (n > NSLOTS) n = NSLOTS;
    return n;
  endfunction

  // lowest slot in use that was never loaded, or -1
  function automatic int first_gap();
    for (int i = 0; i < eff_points(); i++)
      if (!bp_set[i]) return i;
    return -1;
  endfunction

  // clamp at the ends, binary search for the bracket, then y0 + dy*t/dx saturated
  function automatic lerp_res_t lerp_predict(input logic signed [31:0] q);
    lerp_res_t r;
    int n, lo, hi, mid, seg, g;
    bit done, neg;
    longint qq, y0, dy, d, s;
    longint unsigned dx, t, mag, quo;
    n = eff_points();
    qq = q;
    r.f = 1'b0;
    r.y = '0;
    if (qq <= bp_x[0]) begin
      r.y = bp_y[0][31:0];
    end else if (qq >= bp_x[n-1]) begin
      r.y = bp_y[n-1][31:0];
    end else begin
      seg = -1;
      lo = 0;
      hi = n - 2;
      done = 1'b0;
      for (g = 0; g < 64 && !done; g++) begin
        if (lo > hi) begin
          done = 1'b1;
        end else if (lo == hi) begin
          seg = lo;
          done = 1'b1;
        end else begin
          mid = (lo + hi) / 2;
          if (bp_x[mid] <= qq && qq < bp_x[mid+1]) begin
            seg = mid;
            done = 1'b1;
          end else if (qq < bp_x[mid]) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      if (seg < 0 || !(bp_x[seg] <= qq && qq < bp_x[seg+1])) begin
        r.f = 1'b1;
      end else begin
        y0 = bp_y[seg];
        dy = bp_y[seg+1] - y0;
        dx = bp_x[seg+1] - bp_x[seg];
        t = qq - bp_x[seg];
        neg = dy < 0;
        mag = neg ? -dy : dy;
        quo = (mag * t) / dx;
        d = neg ? -longint'(quo) : longint'(quo);
        s = y0 + d;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        r.y = s[31:0];
      end
    end
    return r;
  endfunction

  // result monitor
  always @(posedge clk) begin
    lerp_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_y.size() == 0) begin
        note_bad($sformatf("unexpected word y=%h f=%b", out_ch.result_y, out_ch.search_failed));
      end else begin
        e = pending_y.pop_front();
        if (out_ch.result_y !== e.y || out_ch.search_failed !== e.f)
          note_bad($sformatf("expected y=%h f=%b got y=%h f=%b",
                             e.y, e.f, out_ch.result_y, out_ch.search_failed));
      end
    end
  end

  // receiver: random idling, calm stretches, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_OFF;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // one word on the input channel; valid stays up straight into the next word unless the sender idles
  task automatic send_word(input logic op, input logic [7:0] idx, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] qx,
                           input bit fixed, input logic [31:0] ey, input logic ef);
    lerp_res_t r;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.point_index <= idx;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.query_x <= qx;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (op == OP_LOAD) begin
      bp_x[idx] = longint'($signed(px));
      bp_y[idx] = longint'($signed(py));
      bp_set[idx] = 1'b1;
    end else if (fixed) begin
      r.y = ey;
      r.f = ef;
      pending_y.insert(pending_y.size(), r);
    end else begin
      pending_y.insert(pending_y.size(), lerp_predict(qx));
    end
  endtask

  task automatic load_point(input int idx, input longint x, input longint y);
    send_word(OP_LOAD, idx[7:0], x[31:0], y[31:0], '0, 1'b0, '0, 1'b0);
  endtask

  task automatic query_at(input logic [31:0] q);
    send_word(OP_QUERY, '0, '0, '0, q, 1'b0, '0, 1'b0);
  endtask

  // block idle: nothing owed, then the SETTLE margin for good measure
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_y.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic regsel, input logic [31:0] data);
    logic [31:0] rd;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {regsel, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (regsel == REG_POINTS_IN_USE) pts_shadow = data[8:0];
    // read the count back
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_POINTS_IN_USE, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd !== {23'b0, pts_shadow})
      note_bad($sformatf("points_in_use read %h expected %h", rd, pts_shadow));
  endtask

  function automatic void add_row(row_kind_t kind, logic op, logic [7:0] idx,
                                  logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                                  bit fixed, logic [31:0] ey, logic ef);
    dir_row_t r;
    r.kind = kind; r.op = op; r.idx = idx; r.px = px; r.py = py; r.qx = qx;
    r.fixed = fixed; r.ey = ey; r.ef = ef;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // ascending breakpoints over slots 0..n-1, either spread wide or packed tight
  task automatic load_sweep();
    int n;
    longint span, stp, room, base, x;
    n = eff_points();
    span = 64'd4294967295;
    stp = span / n;
    if ($urandom_range(0, 3) != 0) stp = $urandom_range(1, (stp > 5000) ? 5000 : stp);
    room = span - stp * n;
    base = -64'sd2147483648 + ((room > 0) ? (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff_ffff) % room : 0);
    for (int i = 0; i < n; i++) begin
      x = base + i * stp + ((stp > 1) ? $urandom_range(0, stp - 1) : 0);
      load_point(i, x, longint'($signed($urandom)));
    end
  endtask

  task automatic random_word();
    int n, gap, i, pick;
    longint lo_x, hi_x, q;
    n = eff_points();
    gap = first_gap();
    pick = $urandom_range(0, 99);
    if (gap >= 0) begin
      // never query over a slot that holds nothing yet
      load_point(gap, longint'($signed($urandom)), longint'($signed($urandom)));
    end else if (pick < 10) begin
      // noise load, may break the ordering
      load_point($urandom_range(0, NSLOTS - 1), longint'($signed($urandom)),
                 longint'($signed($urandom)));
    end else if (pick < 40) begin
      query_at($urandom);
    end else if (pick < 85) begin
      i = $urandom_range(0, n - 2);
      lo_x = bp_x[i];
      hi_x = bp_x[i+1];
      q = (hi_x > lo_x) ? lo_x + (longint'($urandom) % (hi_x - lo_x)) : lo_x;
      query_at(q[31:0]);
    end else begin
      case ($urandom_range(0, 3))
        0: query_at(32'h8000_0000);
        1: query_at(32'h7fff_ffff);
        2: query_at(bp_x[0][31:0]);
        default: query_at(bp_x[n-1][31:0]);
      endcase
    end
  endtask

  initial begin
    int ph;
    logic [31:0] cnt;
    longint six_x [6];

    // directed part: ends of the range, clamps, a slot at the top, a broken table
    six_x = '{0, 3, 1, 8, 8, 9};
    add_row(ROW_WORD, OP_LOAD, 8'd0, 32'h0000_0000, 32'h8000_0000, '0, 0, '0, 0);
    add_row(ROW_WORD, OP_LOAD, 8'd1, 32'h0001_0000, 32'h7fff_ffff, '0, 0, '0, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h8000_0000, 1, 32'h8000_0000, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0000_0000, 1, 32'h8000_0000, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0001_0000, 1, 32'h7fff_ffff, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0000_8000, 0, '0, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0000_0001, 0, '0, 0);
    add_row(ROW_WORD, OP_LOAD, 8'd255, 32'h7fff_ffff, 32'hffff_ffff, '0, 0, '0, 0);
    add_row(ROW_CFG, OP_LOAD, '0, 32'd6, '0, '0, 0, '0, 0);
    for (int i = 0; i < 6; i++)
      add_row(ROW_WORD, OP_LOAD, i[7:0], 32'(six_x[i] << 16), (i + 1) * 32'h000a_0000,
              '0, 0, '0, 0);
    // x = 0,3,1,8,8,9 is out of order, yet the search for 2.0 still lands on slot 2
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0002_0000, 0, '0, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h7fff_ffff, 1, 32'h003c_0000, 0);
    add_row(ROW_WORD, OP_LOAD, 8'd0, 32'h8000_0000, 32'h1234_5678, '0, 0, '0, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h8000_0000, 1, 32'h1234_5678, 0);
    add_row(ROW_WORD, OP_QUERY, '0, '0, '0, 32'h0000_0000, 0, '0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        drain();
        reg_write(REG_POINTS_IN_USE, dir_rows[k].px);
      end else begin
        send_word(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].px, dir_rows[k].py,
                  dir_rows[k].qx, dir_rows[k].fixed, dir_rows[k].ey, dir_rows[k].ef);
      end
    end

    // random phases, each with its own point count and usually a freshly loaded table
    ph = 0;
    while (words_sent < 600) begin
      drain();
      case ($urandom_range(0, 9))
        0: cnt = 32'd0;     // acts as two
        1: cnt = 32'd1;
        2: cnt = 32'd256;
        3: cnt = 32'h0000_01ff; // clamps to the table size
        4: cnt = 32'd3;
        default: cnt = $urandom_range(2, 24);
      endcase
      if (ph == 0) cnt = 32'd256;
      if (ph % 4 == 1) reg_write(REG_SPARE, $urandom);   // lands nowhere
      reg_write(REG_POINTS_IN_USE, cnt | ({$urandom} & 32'hffff_fe00));
      calm = (ph == 2);
      if (ph == 1) hold_ask++;
      if (ph == 0 || $urandom_range(0, 99) < 80) load_sweep();
      repeat ($urandom_range(8, 25)) random_word();
      ph++;
    end

    calm = 1'b0;
    drain();
    if (bad_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
